// File: rtl/core/plt_pkg.sv
// Package for the piecewise-linear tone map: curve tables, fixed-point widths,
// pixel and result item types, and the pipeline stage enable struct.
// Used by plt_channel and piecewise_linear_tone_map.
package plt_pkg;

	localparam int unsigned CURVE_POINTS  = 17;
	localparam int unsigned FRACTION_BITS = 16;
	localparam int unsigned RECIP_EXTRA   = 32;

	localparam int unsigned SEG_COUNT  = CURVE_POINTS - 1;
	localparam int unsigned SEG_W      = (SEG_COUNT > 1) ? $clog2(SEG_COUNT) : 1;
	localparam int unsigned VAL_W      = FRACTION_BITS + 1;
	localparam int unsigned RECIP_W    = FRACTION_BITS + RECIP_EXTRA + 1;
	localparam int unsigned RECIP_HI_W = RECIP_W - RECIP_EXTRA;

	localparam logic [VAL_W-1:0] ONE = VAL_W'(1) << FRACTION_BITS;

	// Curve end points in units of 1/10000
	localparam logic [63:0] CURVE_SCALE = 64'd10000;
	localparam logic [63:0] CURVE_HALF  = 64'd5000;

	localparam logic [31:0] CURVE_X_RAW [CURVE_POINTS] = '{
		32'd0, 32'd4, 32'd8, 32'd18, 32'd33, 32'd61, 32'd119, 32'd202, 32'd373,
		32'd650, 32'd1130, 32'd1990, 32'd3000, 32'd4320, 32'd5960, 32'd7670,
		32'd10000
	};

	localparam logic [31:0] CURVE_Y_RAW [CURVE_POINTS] = '{
		32'd0, 32'd590, 32'd1220, 32'd1840, 32'd2470, 32'd3100, 32'd3730,
		32'd4350, 32'd4980, 32'd5610, 32'd6240, 32'd6860, 32'd7490, 32'd8120,
		32'd8750, 32'd9370, 32'd10000
	};

	// Convert a curve entry to unsigned fixed point, rounding half up
	function automatic logic [63:0] to_fixed(input logic [31:0] c);
		return ((64'(c) << FRACTION_BITS) + CURVE_HALF) / CURVE_SCALE;
	endfunction

	typedef struct packed {
		logic [VAL_W-1:0] red_in;
		logic [VAL_W-1:0] green_in;
		logic [VAL_W-1:0] blue_in;
	} pixel_t;

	typedef struct packed {
		logic [VAL_W-1:0] red_out;
		logic [VAL_W-1:0] green_out;
		logic [VAL_W-1:0] blue_out;
	} result_t;

	// Load enables of the six register ranks, s6 being the result register
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
		logic s6;
	} stage_en_t;

endpackage

// File: rtl/core/plt_channel.sv
// One color channel of the tone map: segment search, blend weight from the
// segment reciprocal, and linear interpolation over six register ranks.
// Depends on plt_pkg for the curve tables, widths and stage enables.
module plt_channel
	import plt_pkg::*;
(
	input  logic             clk,
	input  stage_en_t        en,
	input  logic [VAL_W-1:0] value,
	output logic [VAL_W-1:0] mapped
);

	logic [VAL_W-1:0]   seg_x     [SEG_COUNT];
	logic [VAL_W-1:0]   seg_y     [SEG_COUNT];
	logic [VAL_W-1:0]   seg_dy    [SEG_COUNT];
	logic [RECIP_W-1:0] seg_recip [SEG_COUNT];

	for (genvar g = 0; g < SEG_COUNT; g++) begin : g_seg
		localparam logic [63:0] X_LO = to_fixed(CURVE_X_RAW[g]);
		localparam logic [63:0] X_HI = to_fixed(CURVE_X_RAW[g+1]);
		localparam logic [63:0] Y_LO = to_fixed(CURVE_Y_RAW[g]);
		localparam logic [63:0] Y_HI = to_fixed(CURVE_Y_RAW[g+1]);
		localparam logic [63:0] SEG_WIDTH = (X_HI > X_LO) ? (X_HI - X_LO) : 64'd0;
		localparam logic [63:0] SEG_DIV = (SEG_WIDTH == 64'd0) ? 64'd1 : SEG_WIDTH;
		localparam logic [63:0] SEG_RECIP = (SEG_WIDTH == 64'd0) ? 64'd0 :
			(((64'd1 << (FRACTION_BITS + RECIP_EXTRA)) + (SEG_WIDTH >> 1)) / SEG_DIV);
		localparam logic [63:0] SEG_DY = (Y_HI > Y_LO) ? (Y_HI - Y_LO) : 64'd0;

		assign seg_x[g]     = X_LO[VAL_W-1:0];
		assign seg_y[g]     = Y_LO[VAL_W-1:0];
		assign seg_dy[g]    = SEG_DY[VAL_W-1:0];
		assign seg_recip[g] = SEG_RECIP[RECIP_W-1:0];
	end

	// Rank 1: input value
	logic [VAL_W-1:0] v_s1;

	always_ff @(posedge clk) begin
		if (en.s1) begin
			v_s1 <= value;
		end
	end

	// Segment search: the last start point at or below the value wins
	logic                     sat_c;
	logic [SEG_W-1:0]         seg_c;
	logic [VAL_W-1:0]         xk_c;
	logic [FRACTION_BITS-1:0] d_c;

	always_comb begin
		seg_c = '0;
		for (int i = 1; i < SEG_COUNT; i++) begin
			if (seg_x[i] <= v_s1) begin
				seg_c = SEG_W'(i);
			end
		end
	end

	always_comb begin
		logic [VAL_W-1:0] diff;
		sat_c = (v_s1 >= ONE);
		xk_c  = seg_x[seg_c];
		diff  = (v_s1 > xk_c) ? (v_s1 - xk_c) : '0;
		d_c   = diff[FRACTION_BITS-1:0];
	end

	// Rank 2: segment and offset into it
	logic                     sat_s2;
	logic [SEG_W-1:0]         seg_s2;
	logic [FRACTION_BITS-1:0] d_s2;

	always_ff @(posedge clk) begin
		if (en.s2) begin
			sat_s2 <= sat_c;
			seg_s2 <= seg_c;
			d_s2   <= d_c;
		end
	end

	// Rank 3: offset times reciprocal, split into low and high partial products
	logic [RECIP_W-1:0]                   recip_c;
	logic                                 sat_s3;
	logic [SEG_W-1:0]                     seg_s3;
	logic [FRACTION_BITS+RECIP_EXTRA-1:0] plo_s3;
	logic [FRACTION_BITS+RECIP_HI_W-1:0]  phi_s3;

	assign recip_c = seg_recip[seg_s2];

	always_ff @(posedge clk) begin
		if (en.s3) begin
			sat_s3 <= sat_s2;
			seg_s3 <= seg_s2;
			plo_s3 <= (FRACTION_BITS+RECIP_EXTRA)'(d_s2) *
				(FRACTION_BITS+RECIP_EXTRA)'(recip_c[RECIP_EXTRA-1:0]);
			phi_s3 <= (FRACTION_BITS+RECIP_HI_W)'(d_s2) *
				(FRACTION_BITS+RECIP_HI_W)'(recip_c[RECIP_W-1:RECIP_EXTRA]);
		end
	end

	// Round the product to Q1.F and cap the weight at one
	logic [VAL_W-1:0] t_c;

	always_comb begin
		logic [FRACTION_BITS+RECIP_EXTRA:0]   lo_rnd;
		logic [FRACTION_BITS+RECIP_HI_W:0]    t_raw;
		lo_rnd = (FRACTION_BITS+RECIP_EXTRA+1)'(plo_s3) +
			((FRACTION_BITS+RECIP_EXTRA+1)'(1) << (RECIP_EXTRA - 1));
		t_raw  = (FRACTION_BITS+RECIP_HI_W+1)'(phi_s3) +
			(FRACTION_BITS+RECIP_HI_W+1)'(lo_rnd[FRACTION_BITS+RECIP_EXTRA:RECIP_EXTRA]);
		t_c    = (t_raw > (FRACTION_BITS+RECIP_HI_W+1)'(ONE)) ? ONE : t_raw[VAL_W-1:0];
	end

	// Rank 4: blend weight
	logic             sat_s4;
	logic [SEG_W-1:0] seg_s4;
	logic [VAL_W-1:0] t_s4;

	always_ff @(posedge clk) begin
		if (en.s4) begin
			sat_s4 <= sat_s3;
			seg_s4 <= seg_s3;
			t_s4   <= t_c;
		end
	end

	// Rank 5: rise of the segment times weight
	logic               sat_s5;
	logic [SEG_W-1:0]   seg_s5;
	logic [2*VAL_W-1:0] prod_s5;

	always_ff @(posedge clk) begin
		if (en.s5) begin
			sat_s5  <= sat_s4;
			seg_s5  <= seg_s4;
			prod_s5 <= (2*VAL_W)'(seg_dy[seg_s4]) * (2*VAL_W)'(t_s4);
		end
	end

	logic [VAL_W-1:0] res_c;

	always_comb begin
		logic [2*VAL_W:0]       prod_rnd;
		logic [FRACTION_BITS+3:0] sum;
		prod_rnd = (2*VAL_W+1)'(prod_s5) + ((2*VAL_W+1)'(1) << (FRACTION_BITS - 1));
		sum      = (FRACTION_BITS+4)'(seg_y[seg_s5]) +
			(FRACTION_BITS+4)'(prod_rnd[2*VAL_W:FRACTION_BITS]);
		if (sat_s5 || (sum > (FRACTION_BITS+4)'(ONE))) begin
			res_c = ONE;
		end else begin
			res_c = sum[VAL_W-1:0];
		end
	end

	// Rank 6: result register
	logic [VAL_W-1:0] res_s6;

	always_ff @(posedge clk) begin
		if (en.s6) begin
			res_s6 <= res_c;
		end
	end

	assign mapped = res_s6;

endmodule

// File: rtl/core/piecewise_linear_tone_map.sv
// Piecewise-linear tone map, top level: three channel pipelines and handshake.
// Throughput: one pixel per cycle while results are taken; each register rank
// loads whenever it is empty or its successor loads, so bubbles close up while
// a result waits. Reset clears only the rank valid flags; the datapath
// registers are not reset.
// Depends on plt_pkg and plt_channel.
module piecewise_linear_tone_map
	import plt_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    pixel_valid,
	output logic    pixel_ready,
	input  pixel_t  pixel,
	output logic    result_valid,
	input  logic    result_ready,
	output result_t result
);

	logic      vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	stage_en_t en;

	// A rank loads when it holds no item or its successor loads
	always_comb begin
		en.s6 = !vld_s6 || result_ready;
		en.s5 = !vld_s5 || en.s6;
		en.s4 = !vld_s4 || en.s5;
		en.s3 = !vld_s3 || en.s4;
		en.s2 = !vld_s2 || en.s3;
		en.s1 = !vld_s1 || en.s2;
	end

	assign pixel_ready  = en.s1;
	assign result_valid = vld_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			if (en.s1) vld_s1 <= pixel_valid;
			if (en.s2) vld_s2 <= vld_s1;
			if (en.s3) vld_s3 <= vld_s2;
			if (en.s4) vld_s4 <= vld_s3;
			if (en.s5) vld_s5 <= vld_s4;
			if (en.s6) vld_s6 <= vld_s5;
		end
	end

	plt_channel u_red (
		.clk    (clk),
		.en     (en),
		.value  (pixel.red_in),
		.mapped (result.red_out)
	);

	plt_channel u_green (
		.clk    (clk),
		.en     (en),
		.value  (pixel.green_in),
		.mapped (result.green_out)
	);

	plt_channel u_blue (
		.clk    (clk),
		.en     (en),
		.value  (pixel.blue_in),
		.mapped (result.blue_out)
	);

endmodule
